@@ design/ppm_channel_decoder_top_defines.svh @@
// Assertion macros used by the pulse-position decoder checker.
`ifndef PPM_CHANNEL_DECODER_TOP_DEFINES_SVH
`define PPM_CHANNEL_DECODER_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define PPM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same check, but also evaluated while reset is high.
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/ppm_pkg.sv @@
// Package with types, codes and constants of the pulse-position decoder.
package ppm_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int PRESCALE_DEF     = 2;

   // Fixed widths.
   localparam int CNT_W     = 5;   // holds an effective channel count up to 16
   localparam int TICK_W    = 16;
   localparam int US_W      = 33;  // ticks times a prescale of up to 65536
   localparam int DIV_W     = 40;  // scaled pulse difference, times 100
   localparam int DEN_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Operation codes.
   localparam logic [2:0] OP_CAPTURE    = 3'd0;
   localparam logic [2:0] OP_OVERFLOW   = 3'd1;
   localparam logic [2:0] OP_FRAME_GAP  = 3'd2;
   localparam logic [2:0] OP_DISC_CHECK = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;
   localparam logic [2:0] OP_SET_LIMITS = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_MS    = 2'd1;
   localparam logic [1:0] CSR_CLOCKS_PER_US = 2'd2;

   // Reset values.
   localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd8;
   localparam logic [15:0] TIMEOUT_RST       = 16'd20;
   localparam logic [7:0]  CLOCKS_RST        = 8'd48;
   localparam logic [15:0] MIN_US_RST        = 16'd1000;
   localparam logic [15:0] MAX_US_RST        = 16'd2000;

   localparam logic [6:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  channel;
      logic [15:0] pulse_ticks;
      logic [31:0] now_ms;
      logic [15:0] limit_min_us;
      logic [15:0] limit_max_us;
      logic [15:0] limit_deadzone_us;
   } ppm_req_type;

   typedef struct packed {
      logic        status;
      logic [6:0]  percent;
      logic [17:0] pulse_us;
      logic        disconnected;
   } ppm_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV1_GO,
      ST_DIV1_WAIT,
      ST_PCT,
      ST_SCALE,
      ST_DIV2_GO,
      ST_DIV2_WAIT,
      ST_RESP
   } ppm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic mul;
      logic div_go;
      logic div_sel;   // 0: ticks to microseconds, 1: percent
      logic us_load;
      logic pct_prep;
      logic scale;
      logic pct_load;
   } ppm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_go;
      logic scale_done;
      logic div_done;
   } ppm_stat_type;

endpackage

@@ design/ppm_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module ppm_div
   import ppm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic                 fits;

   // One shift-and-subtract step on the partial remainder.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = DIV_CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/ppm_ctrl.sv @@
// Controller state machine that sequences each operation of the decoder.
module ppm_ctrl
   import ppm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ppm_stat_type stat,
   output logic         busy,
   output logic         rsp_valid,
   output ppm_cmd_type  cmd
);

   ppm_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (start) state_in = ST_DECODE;
         ST_DECODE:    state_in = stat.read_go ? ST_MUL : ST_RESP;
         ST_MUL:       state_in = ST_DIV1_GO;
         ST_DIV1_GO:   state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (stat.div_done) state_in = ST_PCT;
         ST_PCT:       state_in = ST_SCALE;
         ST_SCALE:     state_in = stat.scale_done ? ST_RESP : ST_DIV2_GO;
         ST_DIV2_GO:   state_in = ST_DIV2_WAIT;
         ST_DIV2_WAIT: if (stat.div_done) state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd       = '0;
      busy      = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_RESP;
      unique case (state_ff)
         ST_IDLE:      cmd.load = start;
         ST_DECODE:    cmd.exec = 1'b1;
         ST_MUL:       cmd.mul = 1'b1;
         ST_DIV1_GO:   cmd.div_go = 1'b1;
         ST_DIV1_WAIT: cmd.us_load = stat.div_done;
         ST_PCT:       cmd.pct_prep = 1'b1;
         ST_SCALE:     cmd.scale = 1'b1;
         ST_DIV2_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = 1'b1;
         end
         ST_DIV2_WAIT: cmd.pct_load = stat.div_done;
         ST_RESP:      cmd = '0;
         default:      cmd = '0;
      endcase
   end

endmodule

@@ design/ppm_dp.sv @@
// Datapath: configuration, channel slots, limit tables and read arithmetic.
module ppm_dp
   import ppm_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int PRESCALE     = PRESCALE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  ppm_req_type  req_data,
   input  ppm_cmd_type  cmd,
   output ppm_rsp_type  rsp_data,
   output ppm_stat_type stat
);

   localparam int SLOT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [16:0] PRE_MULT = 17'(PRESCALE + 1);

   // Configuration registers.
   logic [3:0]  cfg_count_ff;
   logic [15:0] cfg_timeout_ff;
   logic [7:0]  cfg_clk_ff;

   // Decoder state.
   logic [15:0]       slot_ff [MAX_CHANNELS];
   logic [15:0]       slot_in [MAX_CHANNELS];
   logic [15:0]       min_ff  [MAX_CHANNELS];
   logic [15:0]       min_in  [MAX_CHANNELS];
   logic [15:0]       max_ff  [MAX_CHANNELS];
   logic [15:0]       max_in  [MAX_CHANNELS];
   logic [15:0]       dz_ff   [MAX_CHANNELS];
   logic [15:0]       dz_in   [MAX_CHANNELS];
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic              gap_ff, gap_in;
   logic [31:0]       last_ms_ff, last_ms_in;

   // Item and read pipeline registers.
   ppm_req_type       item_ff, item_in;
   logic [US_W-1:0]   prod_ff, prod_in;
   logic [US_W-1:0]   us_ff, us_in;
   logic [US_W-1:0]   diff_ff, diff_in;
   logic              ge_ff, ge_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   ppm_rsp_type       result_ff, result_in;

   // Combinational helpers.
   logic [CNT_W-1:0]  count;
   logic              ch_ok;
   logic [SLOT_W-1:0] chan_idx;
   logic [3:0]        chan_m1;
   logic [SLOT_W-1:0] ws_base;
   logic [31:0]       elapsed;
   logic              disc;
   logic              bad_limits;
   logic [7:0]        clk_eff;
   logic [15:0]       slot_rd, min_rd, max_rd, dz_rd;
   logic [DIV_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;
   logic              pct_zero;

   // Effective channel count, the selected channel and its table entries.
   always_comb begin
      if (cfg_count_ff == '0 || {1'b0, cfg_count_ff} > CNT_W'(MAX_CHANNELS)) begin
         count = CNT_W'(MAX_CHANNELS);
      end else begin
         count = {1'b0, cfg_count_ff};
      end
      ch_ok    = item_ff.channel != '0 && {1'b0, item_ff.channel} <= count;
      chan_m1  = item_ff.channel - 4'd1;
      chan_idx = chan_m1[SLOT_W-1:0];
      slot_rd  = slot_ff[chan_idx];
      min_rd   = min_ff[chan_idx];
      max_rd   = max_ff[chan_idx];
      dz_rd    = dz_ff[chan_idx];
      clk_eff  = (cfg_clk_ff == '0) ? 8'd1 : cfg_clk_ff;
      elapsed  = item_ff.now_ms - last_ms_ff;
      disc     = elapsed >= {16'd0, cfg_timeout_ff};
      bad_limits = !ch_ok || item_ff.limit_min_us >= item_ff.limit_max_us;
      pct_zero = !ge_ff || diff_ff < US_W'(dz_rd);
   end

   assign stat.read_go    = item_ff.operation == OP_READ && ch_ok;
   assign stat.scale_done = pct_zero || max_rd <= min_rd;
   assign stat.div_done   = div_done;

   // Operand selection for the shared divider.
   always_comb begin
      if (cmd.div_sel) begin
         div_num = num_ff;
         div_den = max_rd - min_rd;
      end else begin
         div_num = DIV_W'(prod_ff);
         div_den = DEN_W'(clk_eff);
      end
   end

   ppm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // State updates of the simple operations.
   always_comb begin
      slot_in    = slot_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      dz_in      = dz_ff;
      wslot_in   = wslot_ff;
      gap_in     = gap_ff;
      last_ms_in = last_ms_ff;
      ws_base    = gap_ff ? '0 : wslot_ff;
      if (CNT_W'(ws_base) >= count) begin
         ws_base = '0;
      end
      if (cmd.exec) begin
         unique case (item_ff.operation)
            OP_CAPTURE: begin
               last_ms_in       = item_ff.now_ms;
               gap_in           = 1'b0;
               slot_in[ws_base] = item_ff.pulse_ticks;
               if (CNT_W'(ws_base) + CNT_W'(1) == count) begin
                  wslot_in = '0;
               end else begin
                  wslot_in = ws_base + SLOT_W'(1);
               end
            end
            OP_OVERFLOW:  wslot_in = '0;
            OP_FRAME_GAP: gap_in = 1'b1;
            OP_DISC_CHECK: begin
               if (disc) begin
                  for (int i = 0; i < MAX_CHANNELS; i++) begin
                     if (CNT_W'(i) < count) begin
                        slot_in[i] = '0;
                     end
                  end
                  wslot_in = '0;
               end
            end
            OP_SET_LIMITS: begin
               if (!bad_limits) begin
                  min_in[chan_idx] = item_ff.limit_min_us;
                  max_in[chan_idx] = item_ff.limit_max_us;
                  dz_in[chan_idx]  = item_ff.limit_deadzone_us;
               end
            end
            default: ;
         endcase
      end
   end

   // Read pipeline and result register.
   always_comb begin
      item_in   = cmd.load ? req_data : item_ff;
      prod_in   = cmd.mul ? ({17'd0, slot_rd} * {16'd0, PRE_MULT}) : prod_ff;
      us_in     = us_ff;
      diff_in   = diff_ff;
      ge_in     = ge_ff;
      num_in    = num_ff;
      result_in = result_ff;
      if (cmd.exec) begin
         result_in = '0;
         result_in.status       = item_ff.operation == OP_SET_LIMITS && bad_limits;
         result_in.disconnected = item_ff.operation == OP_DISC_CHECK && disc;
      end
      if (cmd.us_load) begin
         us_in              = div_quo[US_W-1:0];
         result_in.pulse_us = div_quo[17:0];
      end
      if (cmd.pct_prep) begin
         ge_in   = us_ff >= US_W'(min_rd);
         diff_in = us_ff - US_W'(min_rd);
      end
      if (cmd.scale) begin
         num_in = DIV_W'(diff_ff) * DIV_W'(PCT_FULL);
         if (pct_zero) begin
            result_in.percent = '0;
         end else if (max_rd <= min_rd) begin
            result_in.percent = PCT_FULL;
         end
      end
      if (cmd.pct_load) begin
         result_in.percent = (div_quo > DIV_W'(PCT_FULL)) ? PCT_FULL : div_quo[6:0];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff   <= CHANNEL_COUNT_RST;
         cfg_timeout_ff <= TIMEOUT_RST;
         cfg_clk_ff     <= CLOCKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: cfg_count_ff   <= csr_wdata[3:0];
            CSR_TIMEOUT_MS:    cfg_timeout_ff <= csr_wdata;
            CSR_CLOCKS_PER_US: cfg_clk_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            slot_ff[i] <= '0;
            min_ff[i]  <= MIN_US_RST;
            max_ff[i]  <= MAX_US_RST;
            dz_ff[i]   <= '0;
         end
         wslot_ff   <= '0;
         gap_ff     <= 1'b1;
         last_ms_ff <= '0;
      end else begin
         slot_ff    <= slot_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         dz_ff      <= dz_in;
         wslot_ff   <= wslot_in;
         gap_ff     <= gap_in;
         last_ms_ff <= last_ms_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      prod_ff   <= prod_in;
      us_ff     <= us_in;
      diff_ff   <= diff_in;
      ge_ff     <= ge_in;
      num_ff    <= num_in;
      result_ff <= result_in;
   end

   assign rsp_data = result_ff;

endmodule

@@ design/ppm_channel_decoder_top.sv @@
// Top level of the pulse-position channel decoder.
// An operation is accepted when start is high while busy is low; busy then stays
// high until the result has been shown. Each operation gives exactly one result,
// valid for the single cycle in which rsp_valid is high; the receiver cannot stall
// it and must take it in that cycle. Capture, overflow, frame gap, disconnect check,
// set limits and invalid reads pass from the decode state to the result state.
// A valid read runs through one shared bit-serial divider at one quotient bit per
// cycle: first ticks to microseconds, then, unless the percent is already zero or
// full scale, the percent scaling. A new operation is accepted from the cycle after
// the result strobe. Configuration writes take effect at once and are meant for
// times when no operation is in flight.
module ppm_channel_decoder_top
   import ppm_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int PRESCALE     = PRESCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ppm_req_type req_data,
   output logic        rsp_valid,
   output ppm_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ppm_cmd_type  cmd;
   ppm_stat_type stat;

   ppm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ppm_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .PRESCALE     (PRESCALE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

endmodule

@@ design/ppm_checker.sv @@
// Port-level checker for the decoder top level, bound into every instance.
`include "ppm_channel_decoder_top_defines.svh"

module ppm_checker
   import ppm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input ppm_rsp_type rsp_data
);

   // A transfer makes the block busy in the following cycle.
   `PPM_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not set busy")

   // A result is only shown while an item is in flight.
   `PPM_ASSERT(a_rsp_in_flight, rsp_valid |-> busy, "result strobe without an item in flight")

   // One result per item: the strobe is followed by a free block.
   `PPM_ASSERT(a_rsp_then_idle, rsp_valid |=> (!rsp_valid && !busy), "block not free after result")

   // The percent never exceeds full scale.
   `PPM_ASSERT(a_pct_range, rsp_valid |-> (rsp_data.percent <= PCT_FULL), "percent above 100")

   // Nothing is in flight in the cycle right after reset.
   `PPM_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (!busy && !rsp_valid), "busy after reset")

endmodule

bind ppm_channel_decoder_top ppm_checker u_ppm_checker (.*);
